/* rtl/rcsv_pkg.sv */
`default_nettype none

package rcsv_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LED_IDX_W = 4;
  localparam int unsigned CHAN_W    = 2;

  // character codes the parser looks at
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  // reciprocal of 3 for 8-bit operands: x/3 == (x*171) >> 9
  localparam logic [15:0] DIV3_MUL   = 16'd171;
  localparam int unsigned DIV3_SHIFT = 9;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } rcsv_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]    echo_byte;
    logic                 write_valid;
    logic [LED_IDX_W-1:0] led_index;
    logic [CHAN_W-1:0]    channel;
    logic [BYTE_W-1:0]    value;
    logic                 line_done;
  } rcsv_result_t;

endpackage

`default_nettype wire

/* rtl/rcsv_ifs.sv */
`default_nettype none

interface rcsv_in_if
  import rcsv_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcsv_out_if
  import rcsv_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    echo_byte;
  logic                 write_valid;
  logic [LED_IDX_W-1:0] led_index;
  logic [CHAN_W-1:0]    channel;
  logic [BYTE_W-1:0]    value;
  logic                 line_done;

  modport source (output valid, output echo_byte, output write_valid, output led_index,
                  output channel, output value, output line_done, input ready);
  modport sink   (input valid, input echo_byte, input write_valid, input led_index,
                  input channel, input value, input line_done, output ready);
endinterface

`default_nettype wire

/* rtl/rgb_csv_line_parser_unit.sv */
// RGB CSV line parser.
// rx_i carries received serial bytes, one item each. tx_o returns exactly one
// result item per byte: the byte echoed, an optional color component write
// (led_index, channel, value, flagged by write_valid) and line_done, which marks
// the byte that ends a line so the frame can be refreshed.
// Lines are comma-separated decimal tokens; token t writes LED t/3, channel t%3.
// A line ends at CR/LF or at the byte after LINE_MAX stored bytes (that byte is
// dropped from parsing). A NUL stops parsing until the line end.
// Pipeline: an input register, then the combinational parser state update and
// result logic, then the result register. The result is valid once the item
// has passed the input register and the result register; throughput is one item
// per cycle while tx_o takes results, as the parser core updates once per item.
// When tx_o stalls, the result register holds and the input register still
// takes one more item; rx_i.ready drops only while both registers are full.
// Reset clears both pipeline valids and all parser state (start of a line).

`default_nettype none

module rgb_csv_line_parser_unit
  import rcsv_pkg::*;
#(
  parameter int unsigned LED_COUNT = 16,
  parameter int unsigned LINE_MAX  = 255
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rcsv_in_if.sink     rx_i,
  rcsv_out_if.source  tx_o
);

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_valid_q;
  rcsv_result_t      res_q;
  rcsv_result_t      res_c;
  logic              s1_fire;

  // stage 1 moves into the result register when that is empty or draining
  assign s1_fire    = in_valid_q && (!out_valid_q || tx_o.ready);
  assign rx_i.ready = !in_valid_q || s1_fire;

  rcsv_parse_core #(
    .LED_COUNT (LED_COUNT),
    .LINE_MAX  (LINE_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .byte_i (in_byte_q),
    .res_o  (res_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_i.ready) begin
        in_valid_q <= rx_i.valid;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (tx_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
    if (s1_fire) begin
      res_q <= res_c;
    end
  end

  assign tx_o.valid       = out_valid_q;
  assign tx_o.echo_byte   = res_q.echo_byte;
  assign tx_o.write_valid = res_q.write_valid;
  assign tx_o.led_index   = res_q.led_index;
  assign tx_o.channel     = res_q.channel;
  assign tx_o.value       = res_q.value;
  assign tx_o.line_done   = res_q.line_done;

  // a stalled result must not be overwritten by the parser stage
  a_res_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !tx_o.ready) |=> $stable(res_q))
    else $error("result changed while stalled");

  // every item leaving stage 1 lands in the result register
  a_s1_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("stage 1 item lost");

  // write fields are zero unless a write is flagged
  a_no_write_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.write_valid) |->
      (res_q.led_index == '0 && res_q.channel == '0 && res_q.value == '0))
    else $error("write fields set without write_valid");

  // channel comes from token mod 3
  a_chan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.channel != 2'd3))
    else $error("channel out of range");

endmodule

`default_nettype wire

/* rtl/rcsv_parse_core.sv */
`default_nettype none

module rcsv_parse_core
  import rcsv_pkg::*;
#(
  parameter int unsigned LED_COUNT = 16,
  parameter int unsigned LINE_MAX  = 255
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output rcsv_result_t           res_o
);

  localparam int unsigned TokMax = LED_COUNT * 3;
  localparam int unsigned TokW   = $clog2(TokMax + 1);
  localparam int unsigned CntW   = $clog2(LINE_MAX + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [TokW-1:0]   tok_q, tok_d;
  logic              open_q, open_d;
  rcsv_phase_e       phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [BYTE_W-1:0] acc_q, acc_d;
  logic              ended_q, ended_d;

  always_comb begin
    logic              ws, digit, sign, eol, full, feed, nul, fin, line_end, wr;
    logic [BYTE_W-1:0] acc10, tok8, rem8, val;
    logic [15:0]       prod;
    logic [6:0]        quo;
    logic              open_f, neg_f;
    rcsv_phase_e       phase_f;
    logic [BYTE_W-1:0] acc_f;

    ws    = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
    digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);
    eol   = (byte_i == CH_LF) || (byte_i == CH_CR);
    full  = cnt_q >= CntW'(LINE_MAX);

    feed = !full && !ended_q && (byte_i != CH_NUL) && (byte_i != CH_COMMA);
    nul  = !full && !ended_q && (byte_i == CH_NUL);
    fin  = !ended_q && (full || (byte_i == CH_NUL) || (byte_i == CH_COMMA) || eol);
    // a full line drops the byte, so a CR there does not matter either way
    line_end = full || eol;
    wr = fin && (open_q || feed) && (tok_q < TokW'(TokMax));

    // acc*10 + digit, mod 256; digit value is the low nibble of '0'..'9'
    acc10 = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + {4'b0000, byte_i[3:0]};

    open_f  = open_q;
    neg_f   = neg_q;
    phase_f = phase_q;
    acc_f   = acc_q;
    if (feed) begin
      open_f = 1'b1;
      case (phase_q)
        PH_SKIP: begin
          if (!ws) begin
            if (sign) begin
              neg_f   = (byte_i == CH_MINUS);
              phase_f = PH_DIGITS;
            end else if (digit) begin
              acc_f   = acc10;
              phase_f = PH_DIGITS;
            end else begin
              phase_f = PH_DONE;
            end
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            acc_f = acc10;
          end else begin
            phase_f = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    // led = token/3, channel = token mod 3
    tok8 = BYTE_W'(tok_q);
    prod = {8'h00, tok8} * DIV3_MUL;
    quo  = prod[15:DIV3_SHIFT];
    rem8 = tok8 - ({1'b0, quo} + {quo, 1'b0});
    val  = neg_q ? (8'd0 - acc_q) : acc_q;

    res_o.echo_byte   = byte_i;
    res_o.write_valid = wr;
    res_o.led_index   = wr ? quo[LED_IDX_W-1:0] : '0;
    res_o.channel     = wr ? rem8[CHAN_W-1:0] : '0;
    res_o.value       = wr ? val : '0;
    res_o.line_done   = line_end;

    if (line_end) begin
      cnt_d   = '0;
      tok_d   = '0;
      ended_d = 1'b0;
      open_d  = 1'b0;
      neg_d   = 1'b0;
      phase_d = PH_SKIP;
      acc_d   = '0;
    end else if (fin) begin
      cnt_d   = cnt_q + 1'b1;
      tok_d   = tok_q + TokW'(wr);
      ended_d = ended_q | nul;
      open_d  = 1'b0;
      neg_d   = 1'b0;
      phase_d = PH_SKIP;
      acc_d   = '0;
    end else begin
      cnt_d   = cnt_q + 1'b1;
      tok_d   = tok_q;
      ended_d = ended_q;
      open_d  = open_f;
      neg_d   = neg_f;
      phase_d = phase_f;
      acc_d   = acc_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      tok_q   <= '0;
      open_q  <= 1'b0;
      phase_q <= PH_SKIP;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      cnt_q   <= cnt_d;
      tok_q   <= tok_d;
      open_q  <= open_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      ended_q <= ended_d;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/rgb_csv_line_parser_unit_tb.sv */
`timescale 1ns / 100ps

module rgb_csv_line_parser_unit_tb;
  import rcsv_pkg::*;

  localparam int unsigned LEDS        = 16;
  localparam int unsigned LINE_LIMIT  = 255;
  localparam int unsigned COMP_LIMIT  = LEDS * 3;
  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned CALM_TAIL   = 150;  // last items run with no idling
  localparam int unsigned HOLD_STEP   = 500;  // spacing of sender drain pauses
  localparam int unsigned LONG_STALL  = 80;   // one long receiver hold-off
  localparam int unsigned QUIET_LIMIT = 2000; // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES = 8;

  // one pending rx item; hold = wait for all results before offering it
  typedef struct packed {
    logic              hold;
    logic              calm;
    logic [BYTE_W-1:0] data;
  } rx_item_t;

  logic clk_i;
  logic rst_ni;

  rcsv_in_if  rx_if ();
  rcsv_out_if tx_if ();

  rgb_csv_line_parser_unit #(
    .LED_COUNT(LEDS),
    .LINE_MAX (LINE_LIMIT)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .tx_o  (tx_if)
  );

  rx_item_t     pending_bytes[$];
  rcsv_result_t expected_results[$];

  int unsigned total_bytes;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned err_cnt;
  logic        calm_phase;
  logic        hold_next;
  int unsigned next_hold_at;

  // ---------------------------------------------------------------------------
  // Line parser prediction: own copy of the parser state
  // ---------------------------------------------------------------------------
  logic [7:0]  line_len;    // bytes stored in the current line
  logic [5:0]  comp_idx;    // components written in this line
  logic        tok_open;    // token has begun
  rcsv_phase_e num_phase;
  logic        neg;
  logic [7:0]  acc;
  logic        nul_seen;    // rest of line not parsed

  function automatic void clear_token();
    tok_open  = 1'b0;
    num_phase = PH_SKIP;
    neg       = 1'b0;
    acc       = '0;
  endfunction

  function automatic void restart_line();
    line_len = '0;
    comp_idx = '0;
    nul_seen = 1'b0;
    clear_token();
  endfunction

  // close the open token; fill the component write if one is due
  function automatic void close_component(inout rcsv_result_t r);
    if (tok_open && comp_idx < COMP_LIMIT) begin
      r.write_valid = 1'b1;
      r.led_index   = LED_IDX_W'(comp_idx / 3);
      r.channel     = CHAN_W'(comp_idx % 3);
      r.value       = neg ? 8'(8'd0 - acc) : acc;
      comp_idx      = comp_idx + 6'd1;
    end
    clear_token();
  endfunction

  function automatic void absorb_char(logic [BYTE_W-1:0] c);
    logic ws;
    logic digit;
    ws       = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    tok_open = 1'b1;
    case (num_phase)
      PH_SKIP: begin
        if (ws) begin
          // leading whitespace skipped
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg       = (c == CH_MINUS);
          num_phase = PH_DIGITS;
        end else if (digit) begin
          acc       = 8'(int'(acc) * 10 + int'(c - CH_ZERO));
          num_phase = PH_DIGITS;
        end else begin
          num_phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (digit) acc = 8'(int'(acc) * 10 + int'(c - CH_ZERO));
        else       num_phase = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  // expected result for one accepted byte; advances the parser state
  function automatic rcsv_result_t parse_rx_byte(logic [BYTE_W-1:0] c);
    rcsv_result_t r;
    r           = '0;
    r.echo_byte = c;
    if (line_len >= LINE_LIMIT) begin
      // line full: byte dropped, open token closes, line ends
      if (!nul_seen) close_component(r);
      r.line_done = 1'b1;
      restart_line();
      return r;
    end
    line_len = line_len + 8'd1;
    if (!nul_seen) begin
      if (c == CH_NUL) begin
        close_component(r);
        nul_seen = 1'b1;
      end else if (c == CH_COMMA) begin
        close_component(r);
      end else begin
        absorb_char(c);
      end
    end
    if (c == CH_LF || c == CH_CR) begin
      if (!nul_seen) close_component(r);
      r.line_done = 1'b1;
      restart_line();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void push_byte(logic [BYTE_W-1:0] b);
    rx_item_t it;
    it.hold   = hold_next;
    it.calm   = 1'b0;
    it.data   = b;
    hold_next = 1'b0;
    pending_bytes.push_back(it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_ws();
    case ($urandom_range(0, 3))
      0:       return CH_TAB;
      1:       return 8'h0B;  // vertical tab
      2:       return 8'h0C;  // form feed
      default: return CH_SPACE;
    endcase
  endfunction

  // a line of comma separated numbers with random content and spacing
  function automatic void push_number_line();
    int unsigned ntok;
    int unsigned nul_at;
    ntok   = ($urandom_range(0, 19) == 0) ? $urandom_range(45, 55) : $urandom_range(1, 12);
    nul_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, ntok - 1) : ntok + 1;
    for (int t = 0; t < ntok; t++) begin
      if (t == nul_at) push_byte(CH_NUL);
      if ($urandom_range(0, 4) == 0) push_byte(rand_ws());
      case ($urandom_range(0, 5))
        0:       push_byte(CH_PLUS);
        1:       push_byte(CH_MINUS);
        default: ;
      endcase
      repeat ($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4)) push_byte(rand_digit());
      if ($urandom_range(0, 7) == 0)
        push_byte($urandom_range(0, 1) ? CH_SPACE : 8'(8'h61 + $urandom_range(0, 25)));
      if (t + 1 < ntok) begin
        push_byte(CH_COMMA);
        if ($urandom_range(0, 9) == 0) push_byte(CH_COMMA);
      end else if ($urandom_range(0, 5) == 0) begin
        push_byte(CH_COMMA);  // trailing comma before the line end
      end
    end
    push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endfunction

  // a line that reaches the byte limit; the byte after it is dropped
  function automatic void push_full_line();
    for (int i = 0; i < LINE_LIMIT; i++) begin
      case ($urandom_range(0, 5))
        0:       push_byte(CH_COMMA);
        1:       push_byte(CH_MINUS);
        2:       push_byte(CH_SPACE);
        default: push_byte(rand_digit());
      endcase
    end
    push_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_noise();
    repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) push_byte(CH_LF);
  endfunction

  task automatic build_stimulus();
    int unsigned full_lines;
    int unsigned sel;
    full_lines   = 0;
    hold_next    = 1'b0;
    next_hold_at = 300;
    // directed: extremes, signs, empty tokens, garbage, trailing comma, NUL
    push_text("0,255,-1\n");
    push_text("+7,\n");      // LF after trailing comma gives a zero write
    push_text(" 3x9 ,,\r");  // garbage ends digits, double comma is empty
    push_text("-,300");      // sign alone, wrap modulo 256
    push_byte(CH_NUL);       // parsing stops until the line end
    push_text("8\n");
    // random lines, mostly well formed
    while (pending_bytes.size() < ITEM_TARGET) begin
      if (pending_bytes.size() >= next_hold_at) begin
        hold_next    = 1'b1;
        next_hold_at = next_hold_at + HOLD_STEP;
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        push_number_line();
      end else if (sel < 80 && full_lines < 3) begin
        push_full_line();
        full_lines++;
      end else begin
        push_noise();
      end
    end
    // no pauses of any kind in the tail
    for (int i = pending_bytes.size() - CALM_TAIL; i < pending_bytes.size(); i++) begin
      pending_bytes[i].calm = 1'b1;
      pending_bytes[i].hold = 1'b0;
    end
    total_bytes = pending_bytes.size();
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Byte driver: offers the queue front, holds it until taken. Idle bursts only
  // start between items; a hold item waits until every result is back.
  // ---------------------------------------------------------------------------
  int unsigned send_gap;

  always @(posedge clk_i or negedge rst_ni) begin : drv
    logic              offering;
    logic              nxt_valid;
    logic [BYTE_W-1:0] nxt_byte;
    int unsigned       sent_now;
    if (!rst_ni) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
      bytes_sent    <= 0;
      calm_phase    <= 1'b0;
      send_gap      = 0;
    end else begin
      offering = rx_if.valid && !rx_if.ready;
      sent_now = bytes_sent;
      if (rx_if.valid && rx_if.ready) begin
        expected_results.push_back(parse_rx_byte(pending_bytes[0].data));
        void'(pending_bytes.pop_front());
        sent_now = sent_now + 1;
      end
      nxt_valid = offering;
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_bytes.size() > 0) begin
          if (pending_bytes[0].hold && sent_now != results_seen) begin
            // drain pause: wait for the block to empty
          end else if (!pending_bytes[0].calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 17);
          end else begin
            nxt_valid = 1'b1;
          end
        end
      end
      nxt_byte = nxt_valid ? pending_bytes[0].data : rx_if.rx_byte;
      if (nxt_valid && pending_bytes[0].calm) calm_phase <= 1'b1;
      rx_if.valid   <= nxt_valid;
      rx_if.rx_byte <= nxt_byte;
      bytes_sent    <= sent_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compares each taken result with the oldest expectation and
  // throttles ready. One long hold-off lets the block fill and stall rx.
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  logic        long_stall_done;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : mon
    rcsv_result_t want;
    logic         nxt_ready;
    if (!rst_ni) begin
      tx_if.ready     <= 1'b0;
      results_seen    <= 0;
      stall_left      = 0;
      long_stall_done = 1'b0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual echo %0d",
                   $time, tx_if.echo_byte);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("echo_byte",   want.echo_byte,   tx_if.echo_byte);
          check_field("write_valid", want.write_valid, tx_if.write_valid);
          check_field("led_index",   want.led_index,   tx_if.led_index);
          check_field("channel",     want.channel,     tx_if.channel);
          check_field("value",       want.value,       tx_if.value);
          check_field("line_done",   want.line_done,   tx_if.line_done);
        end
        results_seen <= results_seen + 1;
      end
      nxt_ready = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
      end else if (!long_stall_done && results_seen >= 600) begin
        long_stall_done = 1'b1;
        stall_left      = LONG_STALL - 1;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
      end else begin
        nxt_ready = 1'b1;
      end
      tx_if.ready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long with no handshake on either side ends the run
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build items, reset once, wait for every result, then report
  // ---------------------------------------------------------------------------
  initial begin
    err_cnt      = 0;
    quiet_cycles = 0;
    restart_line();
    build_stimulus();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (results_seen != total_bytes) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results missing, expected echo %0d, actual none",
               $time, expected_results.size(), expected_results[0].echo_byte);
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rcsv_pkg.sv
rtl/rcsv_ifs.sv
rtl/rcsv_parse_core.sv
rtl/rgb_csv_line_parser_unit.sv
tb/sv/rgb_csv_line_parser_unit_tb.sv
